### src/station_probe_log_table_unit_assert.svh
// Assertion macros for the station probe log table unit
`ifndef STATION_PROBE_LOG_TABLE_UNIT_ASSERT_SVH
`define STATION_PROBE_LOG_TABLE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SPLT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SPLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/splt_pkg.sv
// ----------------------------------------------------------------------------
// splt_pkg
// Types, constants and status codes shared by the probe log table modules.
// ----------------------------------------------------------------------------
package splt_pkg;

   localparam int MaxStationsDef   = 64;
   localparam int BssPerStationDef = 8;
   localparam int CountWidthDef    = 16;

   localparam int MacW    = 48;
   localparam int BssW    = 12;
   localparam int WlanW   = 8;
   localparam int OpW     = 2;
   localparam int StatusW = 3;
   localparam int PcW     = 16;
   localparam int StaLogW = 7;
   localparam int BssLogW = 4;
   localparam int CsrW    = 8;

   localparam logic [0:0] CsrBalEnable  = 1'd0;
   localparam logic [0:0] CsrServedWlan = 1'd1;

   typedef enum logic [OpW-1:0] {
      OP_PROBE  = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_COUNTED  = 3'd0,
      ST_NEWBSS   = 3'd1,
      ST_NEWSTA   = 3'd2,
      ST_FULL     = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_NOTFOUND = 3'd5,
      ST_CLEARED  = 3'd6,
      ST_IGNORED  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_APPLY,
      S_RESP
   } state_type;

   // Command broadcast along the cell chain.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PROBE_HIT,
      CMD_NEW_SLOT,
      CMD_NEW_STA,
      CMD_REMOVE,
      CMD_CLEAR
   } cmd_type;

endpackage

### src/splt_cell.sv
// ----------------------------------------------------------------------------
// splt_cell
// One station entry: address, slot table, and a stage of the search chain.
// ----------------------------------------------------------------------------
module splt_cell
   import splt_pkg::*;
#(
   parameter int BssPerStation = BssPerStationDef,
   parameter int CountWidth    = CountWidthDef
) (
   input  logic                  clock,
   input  logic                  reset,
   // search token flowing down the chain
   input  logic                  tok_valid_in_i,
   input  logic [MacW-1:0]       tok_mac_i,
   input  logic                  tok_hit_i,
   input  logic                  tok_free_i,
   output logic                  tok_valid_o,
   output logic [MacW-1:0]       tok_mac_o,
   output logic                  tok_hit_o,
   output logic                  tok_free_o,
   output logic                  hit_here_o,
   output logic                  free_here_o,
   // command for this cell
   input  logic                  sel_i,
   input  cmd_type               cmd_i,
   input  logic [MacW-1:0]       cmd_mac_i,
   input  logic [BssW-1:0]       cmd_bss_i,
   // slot view
   output logic                  valid_o,
   output logic [BssPerStation-1:0] slot_valid_o,
   output logic [BssPerStation-1:0] slot_hit_o,
   output logic [CountWidth-1:0] slot_count_o [BssPerStation]
);

   localparam logic [CountWidth-1:0] CntMax = '1;
   localparam logic [CountWidth-1:0] CntOne = CountWidth'(1);

   logic                     valid_ff;
   logic [MacW-1:0]          mac_ff;
   logic [BssPerStation-1:0] sv_ff;
   logic [BssW-1:0]          bss_ff [BssPerStation];
   logic [CountWidth-1:0]    cnt_ff [BssPerStation];
   logic                     tv_ff, th_ff, tf_ff;
   logic [MacW-1:0]          tm_ff;
   logic                     match;
   logic [BssPerStation-1:0] free_low;

   assign match = valid_ff && (mac_ff == tok_mac_i);

   // Lowest free slot, one-hot.
   assign free_low = ~sv_ff & (sv_ff + BssPerStation'(1));

   always_comb begin
      for (int k = 0; k < BssPerStation; k++) begin
         slot_hit_o[k] = sv_ff[k] && (bss_ff[k] == cmd_bss_i);
      end
   end

   // Pass the token one cell per cycle, accumulate hit and free flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else begin
         tv_ff <= tok_valid_in_i;
      end
      tm_ff <= tok_mac_i;
      th_ff <= tok_hit_i | match;
      tf_ff <= tok_free_i | ~valid_ff;
   end

   assign tok_valid_o = tv_ff;
   assign tok_mac_o   = tm_ff;
   assign tok_hit_o   = th_ff;
   assign tok_free_o  = tf_ff;
   assign hit_here_o  = tok_valid_in_i && match && !tok_hit_i;
   assign free_here_o = tok_valid_in_i && !valid_ff && !tok_free_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sv_ff    <= '0;
      end else if (cmd_i == CMD_CLEAR) begin
         valid_ff <= 1'b0;
         sv_ff    <= '0;
      end else if (sel_i) begin
         case (cmd_i)
            CMD_REMOVE: begin
               valid_ff <= 1'b0;
               sv_ff    <= '0;
            end
            CMD_NEW_STA: begin
               valid_ff <= 1'b1;
               sv_ff    <= BssPerStation'(1);
            end
            CMD_NEW_SLOT: sv_ff <= sv_ff | free_low;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel_i && cmd_i == CMD_NEW_STA) begin
         mac_ff    <= cmd_mac_i;
         bss_ff[0] <= cmd_bss_i;
         cnt_ff[0] <= CntOne;
      end
      for (int k = 0; k < BssPerStation; k++) begin
         if (sel_i && cmd_i == CMD_NEW_SLOT && free_low[k]) begin
            bss_ff[k] <= cmd_bss_i;
            cnt_ff[k] <= CntOne;
         end else if (sel_i && cmd_i == CMD_PROBE_HIT && slot_hit_o[k]
                      && cnt_ff[k] != CntMax) begin
            cnt_ff[k] <= cnt_ff[k] + CntOne;
         end
      end
   end

   assign valid_o      = valid_ff;
   assign slot_valid_o = sv_ff;
   assign slot_count_o = cnt_ff;

endmodule

### src/station_probe_log_table_unit.sv
// ----------------------------------------------------------------------------
// station_probe_log_table_unit
// Per-WLAN probe log: station table as a chain of cells, searched serially.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_opcode .. req_bss_index
//  rsp     | out       | rsp_valid, rsp_stall, rsp_status .. rsp_bss_logged
//  csr     | in        | csr_write, csr_index, csr_data
//
// A transaction is accepted in idle; a search token then walks the cell chain
// one station per cycle, followed by the decide, apply and present steps.
// Reset clears all valid bits at once; no clearing pass. The response
// register holds while rsp_stall is high and the next transaction is taken
// only after the response is accepted.
module station_probe_log_table_unit
   import splt_pkg::*;
#(
   parameter int MaxStations   = MaxStationsDef,
   parameter int BssPerStation = BssPerStationDef,
   parameter int CountWidth    = CountWidthDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [OpW-1:0]     req_opcode,
   input  logic [WlanW-1:0]   req_wlan_number,
   input  logic [MacW-1:0]    req_station_mac,
   input  logic [BssW-1:0]    req_bss_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [StatusW-1:0] rsp_status,
   output logic [PcW-1:0]     rsp_probe_count,
   output logic [StaLogW-1:0] rsp_stations_logged,
   output logic [BssLogW-1:0] rsp_bss_logged,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [CsrW-1:0]    csr_data
);

`include "station_probe_log_table_unit_assert.svh"

   localparam int IdxW = (MaxStations > 1) ? $clog2(MaxStations) : 1;
   localparam int CntW = $clog2(MaxStations + 1);
   localparam int SlW  = $clog2(BssPerStation + 1);

   state_type state_ff, state_in;

   logic               bal_ff;
   logic [WlanW-1:0]   wlan_ff;
   op_type             op_ff;
   logic [WlanW-1:0]   iw_ff;
   logic [MacW-1:0]    mac_ff;
   logic [BssW-1:0]    bss_ff;
   logic [IdxW-1:0]    hit_idx_ff, free_idx_ff, sel_idx_ff;
   logic               hit_ff, free_ff;
   logic [CntW-1:0]    total_ff;
   logic [$clog2(MaxStations+2)-1:0] scan_ff;
   cmd_type            cmd_ff;
   status_type         st_ff;
   logic [StatusW-1:0] rs_ff;
   logic [PcW-1:0]     rc_ff;
   logic [StaLogW-1:0] rt_ff;
   logic [BssLogW-1:0] rb_ff;
   logic               rv_ff;

   // chain wiring
   logic                  tv  [MaxStations+1];
   logic [MacW-1:0]       tm  [MaxStations+1];
   logic                  th  [MaxStations+1];
   logic                  tf  [MaxStations+1];
   logic [MaxStations-1:0] hit_here, free_here;
   logic [BssPerStation-1:0] sv_a  [MaxStations];
   logic [BssPerStation-1:0] sh_a  [MaxStations];
   logic [CountWidth-1:0]    cnt_a [MaxStations][BssPerStation];
   logic [MaxStations-1:0]   vld_a;

   assign tv[0] = (state_ff == S_IDLE) && req_valid;
   assign tm[0] = req_station_mac;
   assign th[0] = 1'b0;
   assign tf[0] = 1'b0;

   for (genvar i = 0; i < MaxStations; i++) begin : g_cell
      splt_cell #(.BssPerStation(BssPerStation), .CountWidth(CountWidth)) u_cell (
         .clock, .reset,
         .tok_valid_in_i(tv[i]), .tok_mac_i(tm[i]), .tok_hit_i(th[i]),
         .tok_free_i(tf[i]),
         .tok_valid_o(tv[i+1]), .tok_mac_o(tm[i+1]), .tok_hit_o(th[i+1]),
         .tok_free_o(tf[i+1]),
         .hit_here_o(hit_here[i]), .free_here_o(free_here[i]),
         .sel_i(sel_idx_ff == IdxW'(i)), .cmd_i(cmd_ff),
         .cmd_mac_i(mac_ff), .cmd_bss_i(bss_ff),
         .valid_o(vld_a[i]), .slot_valid_o(sv_a[i]), .slot_hit_o(sh_a[i]),
         .slot_count_o(cnt_a[i])
      );
   end

   // Note: cell 0 sees the token in the accepting cycle, later cells via the
   // token registers; flags gate only on token valid and fire at most once.
   logic                   s_hit;
   logic [BssPerStation-1:0] s_sv, s_sh, s_fl;
   logic [CountWidth-1:0]  s_cnt;
   logic [SlW-1:0]         s_pop, s_popn;
   logic                   s_any, s_full;

   assign s_sv = sv_a[hit_idx_ff];
   assign s_sh = sh_a[hit_idx_ff];
   assign s_any  = |s_sh;
   assign s_full = &s_sv;
   assign s_fl   = ~s_sv & (s_sv + BssPerStation'(1));

   always_comb begin
      s_cnt = '0;
      s_pop = '0;
      for (int k = 0; k < BssPerStation; k++) begin
         if (s_sh[k]) s_cnt = cnt_a[hit_idx_ff][k];
         s_pop = s_pop + SlW'(s_sv[k]);
      end
   end
   assign s_popn = s_pop + SlW'(1);
   assign s_hit  = hit_ff;

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SCAN;
         S_SCAN:   if (scan_ff == ($bits(scan_ff))'(MaxStations - 1)) state_in = S_DECIDE;
         S_DECIDE: state_in = S_APPLY;
         S_APPLY:  state_in = S_RESP;
         S_RESP:   if (!rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         bal_ff  <= 1'b0;
         wlan_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CsrBalEnable:  bal_ff  <= csr_data[0];
            CsrServedWlan: wlan_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the transaction, collect first hit and first free index.
   // Cell 0 already sees the token in the accepting cycle.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff   <= op_type'(req_opcode);
         iw_ff   <= req_wlan_number;
         mac_ff  <= req_station_mac;
         bss_ff  <= req_bss_index;
         hit_ff  <= |hit_here;
         free_ff <= |free_here;
         scan_ff <= '0;
      end else begin
         if (|hit_here) hit_ff <= 1'b1;
         if (|free_here) free_ff <= 1'b1;
      end
      if (state_ff == S_SCAN) scan_ff <= scan_ff + 1'b1;
      for (int i = 0; i < MaxStations; i++) begin
         if (hit_here[i]) hit_idx_ff <= IdxW'(i);
         if (free_here[i]) free_idx_ff <= IdxW'(i);
      end
   end

   // Decide command and status; apply in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= CMD_NOP;
         total_ff <= '0;
      end else begin
         cmd_ff <= CMD_NOP;
         if (state_ff == S_DECIDE) begin
            st_ff <= ST_IGNORED;
            rc_ff <= '0;
            rb_ff <= '0;
            sel_idx_ff <= hit_idx_ff;
            if (iw_ff == wlan_ff) begin
               case (op_ff)
                  OP_PROBE: if (bal_ff) begin
                     if (s_hit) begin
                        if (s_any) begin
                           cmd_ff <= CMD_PROBE_HIT;
                           st_ff  <= ST_COUNTED;
                           rb_ff  <= BssLogW'(s_pop);
                        end else if (!s_full) begin
                           cmd_ff <= CMD_NEW_SLOT;
                           st_ff  <= ST_NEWBSS;
                           rc_ff  <= PcW'(1);
                           rb_ff  <= BssLogW'(s_popn);
                        end else begin
                           st_ff <= ST_FULL;
                           rb_ff <= BssLogW'(s_pop);
                        end
                     end else if (free_ff) begin
                        cmd_ff     <= CMD_NEW_STA;
                        sel_idx_ff <= free_idx_ff;
                        st_ff      <= ST_NEWSTA;
                        rc_ff      <= PcW'(1);
                        rb_ff      <= BssLogW'(1);
                        total_ff   <= total_ff + 1'b1;
                     end else begin
                        st_ff <= ST_FULL;
                     end
                  end
                  OP_REMOVE: if (s_hit) begin
                     cmd_ff   <= CMD_REMOVE;
                     st_ff    <= ST_REMOVED;
                     total_ff <= total_ff - 1'b1;
                  end else begin
                     st_ff <= ST_NOTFOUND;
                  end
                  OP_CLEAR: begin
                     cmd_ff   <= CMD_CLEAR;
                     st_ff    <= ST_CLEARED;
                     total_ff <= '0;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   // Counted status picks up the bumped count after apply.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         if (state_ff == S_APPLY) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
      end
      if (state_ff == S_APPLY) begin
         rs_ff <= st_ff;
         rt_ff <= StaLogW'(total_ff);
      end
   end

   logic [PcW-1:0] cnt_now;
   assign cnt_now = PcW'(s_cnt);

   assign rsp_valid           = rv_ff;
   assign rsp_status          = rs_ff;
   assign rsp_probe_count     = (status_type'(rs_ff) == ST_COUNTED) ? cnt_now : rc_ff;
   assign rsp_stations_logged = rt_ff;
   assign rsp_bss_logged      = rb_ff;

   `SPLT_ASSERT_IMP(a_rsp_in_resp, clock, reset, rsp_valid, state_ff == S_RESP)
   `SPLT_ASSERT_IMP(a_total_range, clock, reset, 1'b1, total_ff <= CntW'(MaxStations))
   `SPLT_ASSERT_NEXT(a_apply_resp, clock, reset, state_ff == S_APPLY, rsp_valid)

endmodule

### bench/station_probe_log_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_probe_log_table_unit_tb
// Self-checking bench for the per-WLAN station probe log. A driver feeds
// probe, remove and clear transactions from a queue. A software copy of the
// station table predicts each response. A monitor compares every accepted
// response field by field. Phases change the enable, the served WLAN and the
// amount of idling on both channels.
// ----------------------------------------------------------------------------
module station_probe_log_table_unit_tb;
   import splt_pkg::*;

   localparam int NumSta     = MaxStationsDef;
   localparam int NumSlot    = BssPerStationDef;
   localparam int CountSat   = (1 << CountWidthDef) - 1;
   localparam int SettleCyc  = NumSta + 20;   // one transaction plus margin
   localparam int CycleLimit = 600000;

   typedef struct packed {
      op_type           op;
      logic [WlanW-1:0] wlan;
      logic [MacW-1:0]  mac;
      logic [BssW-1:0]  bss;
   } probe_item_type;

   typedef struct packed {
      status_type         status;
      logic [PcW-1:0]     count;
      logic [StaLogW-1:0] stations;
      logic [BssLogW-1:0] slots;
   } log_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OpW-1:0]     req_opcode = '0;
   logic [WlanW-1:0]   req_wlan_number = '0;
   logic [MacW-1:0]    req_station_mac = '0;
   logic [BssW-1:0]    req_bss_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [StatusW-1:0] rsp_status;
   logic [PcW-1:0]     rsp_probe_count;
   logic [StaLogW-1:0] rsp_stations_logged;
   logic [BssLogW-1:0] rsp_bss_logged;
   logic               csr_write = 1'b0;
   logic [0:0]         csr_index = '0;
   logic [CsrW-1:0]    csr_data = '0;

   station_probe_log_table_unit u_dut (.*);

   // Clock. The single reset at the start of the run is released by the test sequence.
   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state: a copy of the station table and the two registers.
   bit              sta_used [NumSta];
   logic [MacW-1:0] sta_mac [NumSta];
   bit [NumSlot-1:0] slot_mask [NumSta];
   logic [BssW-1:0] slot_bss_id [NumSta*NumSlot];
   int              slot_cnt [NumSta*NumSlot];
   int              sta_total;
   bit              bal_en;
   logic [WlanW-1:0] wlan_served;

   probe_item_type pending_items[$];
   log_result_type expected_results[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          mismatches;
   int          cycles;

   function automatic int find_sta(logic [MacW-1:0] mac);
      for (int i = 0; i < NumSta; i++)
         if (sta_used[i] && sta_mac[i] == mac) return i;
      return -1;
   endfunction

   // Apply one transaction to the table copy and return its response.
   function automatic log_result_type apply_log_item(probe_item_type it);
      log_result_type r;
      int s;
      int b;
      bit done;
      r.status = ST_IGNORED;
      r.count  = '0;
      r.slots  = '0;
      done = 1'b0;
      if (it.wlan == wlan_served) begin
         case (it.op)
            OP_PROBE: if (bal_en) begin
               s = find_sta(it.mac);
               if (s >= 0) begin
                  // hit an existing slot first, then take the lowest free one
                  for (int k = 0; k < NumSlot && !done; k++) begin
                     b = s * NumSlot + k;
                     if (slot_mask[s][k] && slot_bss_id[b] == it.bss) begin
                        if (slot_cnt[b] < CountSat) slot_cnt[b]++;
                        r.status = ST_COUNTED;
                        r.count  = PcW'(slot_cnt[b]);
                        done = 1'b1;
                     end
                  end
                  for (int k = 0; k < NumSlot && !done; k++) begin
                     if (!slot_mask[s][k]) begin
                        b = s * NumSlot + k;
                        slot_mask[s][k] = 1'b1;
                        slot_bss_id[b] = it.bss;
                        slot_cnt[b] = 1;
                        r.status = ST_NEWBSS;
                        r.count  = PcW'(1);
                        done = 1'b1;
                     end
                  end
                  if (!done) r.status = ST_FULL;
                  r.slots = BssLogW'($countones(slot_mask[s]));
               end else begin
                  r.status = ST_FULL;
                  for (int i = 0; i < NumSta && !done; i++) begin
                     if (!sta_used[i]) begin
                        sta_used[i] = 1'b1;
                        sta_mac[i] = it.mac;
                        slot_mask[i] = NumSlot'(1);
                        slot_bss_id[i*NumSlot] = it.bss;
                        slot_cnt[i*NumSlot] = 1;
                        sta_total++;
                        r.status = ST_NEWSTA;
                        r.count  = PcW'(1);
                        r.slots  = BssLogW'(1);
                        done = 1'b1;
                     end
                  end
               end
            end
            OP_REMOVE: begin
               s = find_sta(it.mac);
               if (s >= 0) begin
                  sta_used[s] = 1'b0;
                  slot_mask[s] = '0;
                  if (sta_total > 0) sta_total--;
                  r.status = ST_REMOVED;
               end else begin
                  r.status = ST_NOTFOUND;
               end
            end
            OP_CLEAR: begin
               for (int i = 0; i < NumSta; i++) begin
                  sta_used[i] = 1'b0;
                  slot_mask[i] = '0;
               end
               sta_total = 0;
               r.status = ST_CLEARED;
            end
            default: ;
         endcase
      end
      r.stations = StaLogW'(sta_total);
      return r;
   endfunction

   // Driver: predict on acceptance, then hold, advance or idle.
   always @(posedge clock) begin
      probe_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(apply_log_item('{op_type'(req_opcode),
               req_wlan_number, req_station_mac, req_bss_index}));
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_items.pop_front();
               req_opcode      <= nxt.op;
               req_wlan_number <= nxt.wlan;
               req_station_mac <= nxt.mac;
               req_bss_index   <= nxt.bss;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      log_result_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: status %0d count %0d stations %0d bss %0d",
                           rsp_status, rsp_probe_count, rsp_stations_logged, rsp_bss_logged);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_status !== exp_r.status || rsp_probe_count !== exp_r.count ||
                   rsp_stations_logged !== exp_r.stations ||
                   rsp_bss_logged !== exp_r.slots) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              exp_r.status, exp_r.count, exp_r.stations, exp_r.slots,
                              rsp_status, rsp_probe_count, rsp_stations_logged,
                              rsp_bss_logged);
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("station_probe_log_table_unit verification failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || expected_results.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SettleCyc) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [CsrW-1:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      if (idx == CsrBalEnable) bal_en = val[0];
      else wlan_served = val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic push(op_type op, logic [WlanW-1:0] w, logic [MacW-1:0] m,
                       logic [BssW-1:0] b);
      pending_items.push_back('{op, w, m, b});
   endtask

   // Random traffic: mostly well-formed probes on a small station and BSS
   // pool so that slots and the table fill, with removes, clears and noise.
   task automatic random_traffic(int n);
      logic [MacW-1:0] macs [80];
      logic [BssW-1:0] bsss [12];
      int pool;
      int r;
      logic [WlanW-1:0] w;
      foreach (macs[i]) macs[i] = MacW'({$urandom(), $urandom()});
      foreach (bsss[i]) bsss[i] = BssW'($urandom());
      pool = $urandom_range(1) ? 80 : 20;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         w = WlanW'($urandom());
         if (w == wlan_served) w = ~wlan_served;
         if (r < 72)
            push(OP_PROBE, wlan_served, macs[$urandom_range(pool-1)],
                 bsss[$urandom_range(11)]);
         else if (r < 84)
            push(OP_REMOVE, wlan_served, macs[$urandom_range(pool-1)],
                 BssW'($urandom()));
         else if (r < 86)
            push(OP_CLEAR, wlan_served, MacW'({$urandom(), $urandom()}),
                 BssW'($urandom()));
         else if (r < 94)
            push(op_type'($urandom_range(3)), w, MacW'({$urandom(), $urandom()}),
                 BssW'($urandom()));
         else
            push(OP_NONE, wlan_served, MacW'({$urandom(), $urandom()}),
                 BssW'($urandom()));
      end
   endtask

   initial begin
      logic [MacW-1:0] sta_a;
      bal_en = 1'b0;
      wlan_served = '0;
      sta_total = 0;
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Phase 1: directed checks, then random traffic, no idling.
      write_reg(CsrBalEnable, 8'd1);
      write_reg(CsrServedWlan, 8'h5A);
      sta_a = 48'h0012_3456_789A;
      push(OP_REMOVE, 8'h5A, sta_a, '0);              // remove on an empty log
      push(OP_PROBE, 8'h5A, sta_a, 12'd0);            // new station
      push(OP_PROBE, 8'h5A, sta_a, 12'd0);            // counted
      push(OP_PROBE, 8'h5A, sta_a, 12'hFFF);          // new BSS
      for (int k = 1; k < NumSlot - 1; k++) push(OP_PROBE, 8'h5A, sta_a, 12'(k * 3));
      push(OP_PROBE, 8'h5A, sta_a, 12'h800);          // slots full
      push(OP_PROBE, 8'h5A, '1, 12'h555);
      push(OP_PROBE, 8'h5A, '0, 12'hAAA);
      push(OP_PROBE, 8'hA5, sta_a, 12'd0);            // WLAN mismatch
      push(OP_NONE, 8'h5A, sta_a, 12'd0);             // unknown opcode
      push(OP_REMOVE, 8'h5A, sta_a, '0);
      push(OP_REMOVE, 8'h5A, sta_a, '0);              // absent station
      push(OP_CLEAR, 8'h5A, '0, '0);
      // Fill the station table, then one more to hit the full case.
      for (int i = 0; i <= NumSta; i++) push(OP_PROBE, 8'h5A, 48'(i * 7919 + 1), 12'(i));
      push(OP_REMOVE, 8'h5A, 48'(30 * 7919 + 1), '0);
      push(OP_PROBE, 8'h5A, 48'hFEED, 12'd9);         // reuses the freed entry
      push(OP_CLEAR, 8'h5A, '0, '0);
      random_traffic(100);
      wait_drained();

      // Phase 2: sender mostly idle, top WLAN number.
      send_idle_pct = 80;
      write_reg(CsrServedWlan, 8'hFF);
      random_traffic(100);
      wait_drained();

      // Phase 3: balancing off, receiver mostly stalling, WLAN zero.
      send_idle_pct = 0;
      recv_stall_pct = 80;
      write_reg(CsrBalEnable, 8'd0);
      write_reg(CsrServedWlan, 8'h00);
      random_traffic(60);
      wait_drained();

      // Phase 4: balancing back on, both sides idling.
      send_idle_pct = 25;
      recv_stall_pct = 25;
      write_reg(CsrBalEnable, 8'd1);
      write_reg(CsrServedWlan, 8'hA5);
      random_traffic(150);
      wait_drained();

      if (mismatches == 0 && expected_results.size() == 0)
         $display("station_probe_log_table_unit verification clean");
      else
         $display("station_probe_log_table_unit verification failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/splt_pkg.sv
src/splt_cell.sv
src/station_probe_log_table_unit.sv
bench/station_probe_log_table_unit_tb.sv
